>>> hdl/encoder_speed_pid_core_assert.svh
// Assertion macros for the checker file of this block.
// Each macro takes a label, the clock, a disable condition and the two sides
// of the implication.
`ifndef ENCODER_SPEED_PID_CORE_ASSERT_SVH
`define ENCODER_SPEED_PID_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ESPID_ASSERT_SAME(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("espid assertion failed: same-cycle implication");

// Consequent checked in the cycle after the antecedent.
`define ESPID_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("espid assertion failed: next-cycle implication");

`endif

>>> hdl/espid_pkg.sv
`timescale 1ns / 1ps

package espid_pkg;

   localparam int COUNT_W    = 16;
   localparam int SETPOINT_W = 16;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 31;
   localparam int ERR_W      = 18;
   localparam int DELTA_W    = ERR_W + 1;
   localparam int INTEG_W    = 32;
   localparam int DRIVE_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   // Counts at or above the fold point are read as the counter running backward.
   localparam logic [COUNT_W-1:0] FOLD_POINT    = COUNT_W'(500);
   localparam logic [ERR_W-1:0]   COUNT_MODULUS = ERR_W'(1000);

   localparam logic signed [SETPOINT_W-1:0] SETPOINT_RESET = SETPOINT_W'(90);
   localparam logic [LIMIT_W-1:0]           LIMIT_RESET    = {LIMIT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT       = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_INTEGRAL_LIMIT = 3'd4
   } csr_index_type;

   // Values handed from the error stage to the multiply stage.
   typedef struct packed {
      logic signed [ERR_W-1:0]   error;
      logic signed [INTEG_W-1:0] integral;
      logic signed [DELTA_W-1:0] delta;
      logic                      force_zero;
   } mid_type;

endpackage

>>> hdl/espid_req_if.sv
`timescale 1ns / 1ps

interface espid_req_if;
   import espid_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] encoder_count;
   logic               clear_integral;

   modport source (output valid, output encoder_count, output clear_integral, input ready);
   modport sink (input valid, input encoder_count, input clear_integral, output ready);
endinterface

>>> hdl/espid_rsp_if.sv
`timescale 1ns / 1ps

interface espid_rsp_if;
   import espid_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive_value;

   modport source (output valid, output drive_value, input ready);
   modport sink (input valid, input drive_value, output ready);
endinterface

>>> hdl/espid_err.sv
`timescale 1ns / 1ps

module espid_err (
   input  logic [espid_pkg::COUNT_W-1:0]           count,
   input  logic                                    clear,
   input  logic signed [espid_pkg::SETPOINT_W-1:0] setpoint,
   input  logic [espid_pkg::LIMIT_W-1:0]           limit,
   input  logic signed [espid_pkg::INTEG_W-1:0]    integral,
   input  logic signed [espid_pkg::ERR_W-1:0]      last_error,
   output espid_pkg::mid_type                      mid,
   output logic signed [espid_pkg::INTEG_W-1:0]    integral_next
);
   import espid_pkg::*;

   localparam logic signed [INTEG_W:0] INTEG_MIN = {2'b11, {(INTEG_W-1){1'b0}}};

   logic                      fold;
   logic signed [ERR_W-1:0]   count_ext;
   logic signed [ERR_W-1:0]   setpoint_ext;
   logic signed [ERR_W-1:0]   error;
   logic signed [INTEG_W-1:0] base;
   logic signed [INTEG_W:0]   sum;
   logic signed [INTEG_W:0]   limit_ext;
   logic signed [INTEG_W-1:0] clamped;
   logic                      setpoint_zero;

   assign fold         = (count >= FOLD_POINT);
   assign count_ext    = {{(ERR_W-COUNT_W){1'b0}}, count};
   assign setpoint_ext = {{(ERR_W-SETPOINT_W){setpoint[SETPOINT_W-1]}}, setpoint};

   // The sum always lands inside 18 signed bits, so wrapping arithmetic is exact.
   assign error = fold ? (setpoint_ext - COUNT_MODULUS + count_ext)
                       : (setpoint_ext - count_ext);

   assign base      = clear ? '0 : integral;
   assign sum       = {base[INTEG_W-1], base} + {{(INTEG_W+1-ERR_W){error[ERR_W-1]}}, error};
   assign limit_ext = {{(INTEG_W+1-LIMIT_W){1'b0}}, limit};

   always_comb begin
      priority if (sum > limit_ext) begin
         clamped = limit_ext[INTEG_W-1:0];
      end else if (sum < INTEG_MIN) begin
         clamped = INTEG_MIN[INTEG_W-1:0];
      end else begin
         clamped = sum[INTEG_W-1:0];
      end
   end

   assign setpoint_zero = (setpoint == '0);

   assign mid.error      = error;
   assign mid.integral   = clamped;
   assign mid.delta      = {error[ERR_W-1], error} - {last_error[ERR_W-1], last_error};
   assign mid.force_zero = setpoint_zero;

   assign integral_next = setpoint_zero ? '0 : clamped;
endmodule

>>> hdl/espid_mac.sv
`timescale 1ns / 1ps

module espid_mac (
   input  espid_pkg::mid_type                   mid,
   input  logic signed [espid_pkg::GAIN_W-1:0]  gain_p,
   input  logic signed [espid_pkg::GAIN_W-1:0]  gain_i,
   input  logic signed [espid_pkg::GAIN_W-1:0]  gain_d,
   output logic signed [espid_pkg::DRIVE_W-1:0] drive
);
   import espid_pkg::*;

   localparam int PROD_P_W = GAIN_W + ERR_W;
   localparam int PROD_I_W = GAIN_W + INTEG_W;
   localparam int PROD_D_W = GAIN_W + DELTA_W;
   localparam int ACC_W    = PROD_I_W + 2;
   localparam int FRAC_W   = 8;
   localparam int SHIFT_W  = ACC_W - FRAC_W;

   logic signed [PROD_P_W-1:0] prod_p;
   logic signed [PROD_I_W-1:0] prod_i;
   logic signed [PROD_D_W-1:0] prod_d;
   logic signed [ACC_W-1:0]    acc;
   logic signed [SHIFT_W-1:0]  shifted;
   logic                       fits;

   assign prod_p = gain_p * mid.error;
   assign prod_i = gain_i * mid.integral;
   assign prod_d = gain_d * mid.delta;

   assign acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

   // Dropping the fraction bits of a two's complement value rounds toward minus infinity.
   assign shifted = acc[ACC_W-1:FRAC_W];

   // The value fits when every bit above the result's sign matches that sign.
   assign fits = (shifted[SHIFT_W-1:DRIVE_W-1] == '0) ||
                 (shifted[SHIFT_W-1:DRIVE_W-1] == '1);

   always_comb begin
      priority if (mid.force_zero) begin
         drive = '0;
      end else if (fits) begin
         drive = shifted[DRIVE_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         drive = {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
         drive = {1'b0, {(DRIVE_W-1){1'b1}}};
      end
   end
endmodule

>>> hdl/encoder_speed_pid_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload                          Handshake
// req_if    in         encoder_count, clear_integral    valid / ready
// rsp_if    out        drive_value                      valid / ready
// csr_*     in         csr_index, csr_wdata             csr_write_en, no stall
//
// A transaction is accepted every cycle while the result side keeps up.
// The error and integral update happen on the accepting edge, which also loads
// mid_ff; the three gain multiplies and the saturation work on mid_ff and load
// drive_ff, whose value is the result offered on rsp_if.
// One stage buffers a request while a result waits.
// Reset is synchronous; req_if.ready stays low while reset is high.

module encoder_speed_pid_core (
   input  logic                                  clock,
   input  logic                                  reset,
   espid_req_if.sink                             req_if,
   espid_rsp_if.source                           rsp_if,
   input  logic                                  csr_write_en,
   input  logic [espid_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [espid_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import espid_pkg::*;

   logic signed [SETPOINT_W-1:0] setpoint_ff;
   logic signed [GAIN_W-1:0]     gain_p_ff;
   logic signed [GAIN_W-1:0]     gain_i_ff;
   logic signed [GAIN_W-1:0]     gain_d_ff;
   logic [LIMIT_W-1:0]           limit_ff;

   logic signed [INTEG_W-1:0]    integral_ff;
   logic signed [INTEG_W-1:0]    integral_in;
   logic signed [ERR_W-1:0]      last_error_ff;

   mid_type                      mid_ff;
   mid_type                      mid_in;
   logic                         mid_valid_ff;

   logic                         rsp_valid_ff;
   logic signed [DRIVE_W-1:0]    drive_ff;
   logic signed [DRIVE_W-1:0]    drive_in;

   logic                         out_move;
   logic                         mid_move;
   logic                         accept;

   assign out_move      = !rsp_valid_ff || rsp_if.ready;
   assign mid_move      = !mid_valid_ff || out_move;
   assign req_if.ready  = mid_move && !reset;
   assign accept        = req_if.valid && req_if.ready;

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.drive_value = drive_ff;

   espid_err u_err (
      .count         (req_if.encoder_count),
      .clear         (req_if.clear_integral),
      .setpoint      (setpoint_ff),
      .limit         (limit_ff),
      .integral      (integral_ff),
      .last_error    (last_error_ff),
      .mid           (mid_in),
      .integral_next (integral_in)
   );

   espid_mac u_mac (
      .mid    (mid_ff),
      .gain_p (gain_p_ff),
      .gain_i (gain_i_ff),
      .gain_d (gain_d_ff),
      .drive  (drive_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= SETPOINT_RESET;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         limit_ff      <= LIMIT_RESET;
         integral_ff   <= '0;
         last_error_ff <= '0;
         mid_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_SETPOINT:       setpoint_ff <= csr_wdata[SETPOINT_W-1:0];
               CSR_GAIN_P:         gain_p_ff   <= csr_wdata[GAIN_W-1:0];
               CSR_GAIN_I:         gain_i_ff   <= csr_wdata[GAIN_W-1:0];
               CSR_GAIN_D:         gain_d_ff   <= csr_wdata[GAIN_W-1:0];
               CSR_INTEGRAL_LIMIT: limit_ff    <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         // Loop state moves on the accepting edge so the next transaction sees it.
         if (accept) begin
            integral_ff   <= integral_in;
            last_error_ff <= mid_in.error;
         end
         if (mid_move) begin
            mid_valid_ff <= accept;
         end
         if (out_move) begin
            rsp_valid_ff <= mid_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_ff <= mid_in;
      end
      if (out_move && mid_valid_ff) begin
         drive_ff <= drive_in;
      end
   end
endmodule

>>> hdl/espid_checker.sv
`timescale 1ns / 1ps

`include "encoder_speed_pid_core_assert.svh"

module espid_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [espid_pkg::DRIVE_W-1:0]  drive_value
);
   // A result that is not taken stays offered unchanged.
   `ESPID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(drive_value))

   // No result is offered in the cycle after reset.
   `ESPID_ASSERT_SAME(a_rsp_reset, clock, 1'b0, $past(reset), !rsp_valid)

   // An empty result register only fills from an accepted transaction held in mid_ff.
   `ESPID_ASSERT_SAME(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

   // Nothing is accepted while reset is high.
   `ESPID_ASSERT_SAME(a_req_reset, clock, 1'b0, reset, !req_ready)
endmodule

bind encoder_speed_pid_core espid_checker u_espid_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .drive_value (rsp_if.drive_value)
);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import espid_pkg::*;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam logic [CSR_IDX_W-1:0] NO_REG           = '0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNUSED  = 3'd7;
   localparam int FLOOD_ITEMS = 200;

   typedef enum logic {ROW_WRITE, ROW_READING} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_IDX_W-1:0]      idx;
      logic [CSR_DATA_W-1:0]     data;
      logic [COUNT_W-1:0]        count;
      logic                      clr;
      logic                      pinned;
      logic signed [DRIVE_W-1:0] want;
   } dir_row_type;

   localparam int N_ROWS = 45;
   localparam dir_row_type DIRECTED_ROWS [N_ROWS] = '{
      // Out of reset all gains are zero.
      '{ROW_READING, NO_REG, 31'd0, 16'd0,     1'b0, 1'b1, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd65535, 1'b1, 1'b1, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd499,   1'b0, 1'b1, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd500,   1'b0, 1'b1, 32'sd0},
      // Unity proportional gain: the drive value is the error itself.
      '{ROW_WRITE, CSR_SETPOINT, 31'd100,   16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_GAIN_P,   31'h100,   16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd0,     1'b0, 1'b1, 32'sd100},
      '{ROW_READING, NO_REG, 31'd0, 16'd499,   1'b0, 1'b1, -32'sd399},
      '{ROW_READING, NO_REG, 31'd0, 16'd500,   1'b0, 1'b1, -32'sd400},
      '{ROW_READING, NO_REG, 31'd0, 16'd1000,  1'b0, 1'b1, 32'sd100},
      '{ROW_READING, NO_REG, 31'd0, 16'd65535, 1'b0, 1'b1, 32'sd64635},
      // Unity integral gain with a low clamp.
      '{ROW_WRITE, CSR_GAIN_P,         31'd0,   16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_GAIN_I,         31'h100, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_INTEGRAL_LIMIT, 31'd150, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd0,     1'b1, 1'b1, 32'sd100},
      '{ROW_READING, NO_REG, 31'd0, 16'd0,     1'b0, 1'b1, 32'sd150},
      '{ROW_READING, NO_REG, 31'd0, 16'd0,     1'b0, 1'b1, 32'sd150},
      '{ROW_READING, NO_REG, 31'd0, 16'd499,   1'b0, 1'b1, -32'sd249},
      '{ROW_WRITE, CSR_INTEGRAL_LIMIT, 31'd0,   16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd0,     1'b1, 1'b1, 32'sd0},
      // Zero setpoint, written with junk in the unused upper bits.
      '{ROW_WRITE, CSR_GAIN_P,         31'h100,       16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_INTEGRAL_LIMIT, 31'h7FFF_FFFF, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_SETPOINT,       31'h7FFF_0000, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd1000,  1'b0, 1'b1, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd65535, 1'b0, 1'b1, 32'sd0},
      '{ROW_WRITE, CSR_SETPOINT,       31'h5555_0001, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd0,     1'b0, 1'b1, 32'sd2},
      // Extreme gains and setpoints.
      '{ROW_WRITE, CSR_SETPOINT, 31'h7FFF_7FFF, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_GAIN_P,   31'h0000_8000, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_GAIN_I,   31'h0000_7FFF, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_GAIN_D,   31'h0000_7FFF, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd65535, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd0,     1'b1, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd499,   1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd500,   1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_SETPOINT, 31'h0000_8000, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_GAIN_D,   31'h0000_8000, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_GAIN_I,   31'h0000_8000, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd499,   1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd65535, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd0,     1'b1, 1'b0, 32'sd0},
      // Writes to indexes past the last register must change nothing.
      '{ROW_WRITE, CSR_FIRST_UNUSED, 31'h7FFF_FFFF, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_WRITE, CSR_LAST_UNUSED,  31'h7FFF_FFFF, 16'd0, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd12345, 1'b0, 1'b0, 32'sd0},
      '{ROW_READING, NO_REG, 31'd0, 16'd999,   1'b1, 1'b0, 32'sd0}
   };

   logic clock;
   logic reset;
   logic                       csr_write_en;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;
   logic                       req_pinned;
   logic signed [DRIVE_W-1:0]  req_want;

   espid_req_if req_if ();
   espid_rsp_if rsp_if ();

   encoder_speed_pid_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Shadow copy of the loop registers and state.
   logic signed [SETPOINT_W-1:0] sp_reg;
   logic signed [GAIN_W-1:0]     kp_reg;
   logic signed [GAIN_W-1:0]     ki_reg;
   logic signed [GAIN_W-1:0]     kd_reg;
   logic [LIMIT_W-1:0]           limit_reg;
   logic signed [INTEG_W-1:0]    integ;
   logic signed [ERR_W-1:0]      prev_err;

   logic signed [DRIVE_W-1:0] drive_q [$];

   int send_idle_pct;
   int rcv_idle_pct;
   int failures;
   int readings;
   int checked;
   int reg_writes;
   int drive_sat_hits;
   int floor_hits;
   int clamp_hits;

   function automatic logic signed [DRIVE_W-1:0] advance_speed_loop(
      input logic [COUNT_W-1:0] cnt, input logic clr);
      longint err;
      longint sum;
      longint acc;
      longint drive;
      if (clr)
         integ = '0;
      if (cnt < FOLD_POINT)
         err = longint'(sp_reg) - longint'(cnt);
      else
         err = longint'(sp_reg) - (longint'(COUNT_MODULUS) - longint'(cnt));
      sum = longint'(integ) + err;
      if (sum > longint'(limit_reg)) begin
         sum = longint'(limit_reg);
         clamp_hits++;
      end
      if (sum < S32_MIN) begin
         sum = S32_MIN;
         floor_hits++;
      end
      integ = sum[INTEG_W-1:0];
      acc = longint'(kp_reg) * err + longint'(ki_reg) * longint'(integ)
            + longint'(kd_reg) * (err - longint'(prev_err));
      drive = acc >>> 8;
      if (drive > S32_MAX) begin
         drive = S32_MAX;
         drive_sat_hits++;
      end
      if (drive < S32_MIN) begin
         drive = S32_MIN;
         drive_sat_hits++;
      end
      if (sp_reg == 0) begin
         integ = '0;
         drive = 0;
      end
      prev_err = err[ERR_W-1:0];
      return drive[DRIVE_W-1:0];
   endfunction

   task automatic note_failure(input string what, input logic signed [DRIVE_W-1:0] want,
                               input logic signed [DRIVE_W-1:0] got);
      failures++;
      if (failures <= 10)
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Both handshakes and the register port are observed at the same edge, so the
   // order of prediction, checking and register update is fixed.
   always @(posedge clock) begin
      logic signed [DRIVE_W-1:0] predicted;
      logic signed [DRIVE_W-1:0] want;
      if (reset) begin
         sp_reg    = SETPOINT_RESET;
         kp_reg    = '0;
         ki_reg    = '0;
         kd_reg    = '0;
         limit_reg = LIMIT_RESET;
         integ     = '0;
         prev_err  = '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predicted = advance_speed_loop(req_if.encoder_count, req_if.clear_integral);
            drive_q.push_back(req_pinned ? req_want : predicted);
            readings++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (drive_q.size() == 0) begin
               note_failure("drive value with no transaction pending", '0,
                            rsp_if.drive_value);
            end else begin
               want = drive_q.pop_front();
               if (rsp_if.drive_value !== want)
                  note_failure("drive_value mismatch", want, rsp_if.drive_value);
            end
            checked++;
         end
         if (csr_write_en) begin
            reg_writes++;
            case (csr_index)
               CSR_SETPOINT:       sp_reg = csr_wdata[SETPOINT_W-1:0];
               CSR_GAIN_P:         kp_reg = csr_wdata[GAIN_W-1:0];
               CSR_GAIN_I:         ki_reg = csr_wdata[GAIN_W-1:0];
               CSR_GAIN_D:         kd_reg = csr_wdata[GAIN_W-1:0];
               CSR_INTEGRAL_LIMIT: limit_reg = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   task automatic send_reading(input logic [COUNT_W-1:0] cnt, input logic clr,
                               input logic pinned, input logic signed [DRIVE_W-1:0] want);
      csr_write_en <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.encoder_count  <= cnt;
      req_if.clear_integral <= clr;
      req_pinned            <= pinned;
      req_want              <= want;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   // Registers change only once every pending transaction has produced its result.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      csr_write_en <= 1'b0;
      @(posedge clock);
      while (drive_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   // Random register word, biased toward the ends of the range. The bits above a
   // 16-bit register's width are random so that truncation is exercised.
   function automatic logic [CSR_DATA_W-1:0] pick_reg_word(input logic is_limit);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'($urandom);
      if (is_limit) begin
         case ($urandom_range(5))
            0: word = '0;
            1: word = '1;
            2: word = CSR_DATA_W'($urandom_range(2000));
            3: word = CSR_DATA_W'($urandom_range(200000));
            default: ;
         endcase
      end else begin
         case ($urandom_range(9))
            0: word[15:0] = 16'h8000;
            1: word[15:0] = 16'h7FFF;
            2: word[15:0] = 16'h0000;
            3: word[15:0] = 16'hFFFF;
            4: word[15:0] = 16'($urandom_range(1024)) - 16'd512;
            default: ;
         endcase
      end
      return word;
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      logic [COUNT_W-1:0] cnt;
      case ($urandom_range(9))
         0, 1, 2, 3: cnt = COUNT_W'($urandom_range(999));
         4:          cnt = COUNT_W'($urandom_range(505, 495));
         5: begin
            case ($urandom_range(3))
               0: cnt = '0;
               1: cnt = '1;
               2: cnt = 16'd999;
               default: cnt = 16'd1000;
            endcase
         end
         default: cnt = COUNT_W'($urandom);
      endcase
      return cnt;
   endfunction

   initial begin
      int row;
      int phase;
      int blk;
      int n;
      int drain_cycles;
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.encoder_count  <= '0;
      req_if.clear_integral <= 1'b0;
      req_pinned            <= 1'b0;
      req_want              <= '0;
      csr_write_en          <= 1'b0;
      csr_index             <= '0;
      csr_wdata             <= '0;
      send_idle_pct = 28;
      rcv_idle_pct  = 88;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < N_ROWS; row++) begin
         if (DIRECTED_ROWS[row].kind == ROW_WRITE) begin
            if (row == 0 || DIRECTED_ROWS[row-1].kind == ROW_READING)
               wait_for_drain();
            write_reg(DIRECTED_ROWS[row].idx, DIRECTED_ROWS[row].data);
         end else begin
            send_reading(DIRECTED_ROWS[row].count, DIRECTED_ROWS[row].clr,
                         DIRECTED_ROWS[row].pinned, DIRECTED_ROWS[row].want);
         end
      end

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 28; rcv_idle_pct = 88; end
            1: begin send_idle_pct = 88; rcv_idle_pct = 28; end
            default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
         endcase
         for (blk = 0; blk < 4; blk++) begin
            wait_for_drain();
            write_reg(CSR_SETPOINT, pick_reg_word(1'b0));
            write_reg(CSR_GAIN_P, pick_reg_word(1'b0));
            write_reg(CSR_GAIN_I, pick_reg_word(1'b0));
            write_reg(CSR_GAIN_D, pick_reg_word(1'b0));
            write_reg(CSR_INTEGRAL_LIMIT, pick_reg_word(1'b1));
            if ($urandom_range(3) == 0)
               write_reg(CSR_IDX_W'($urandom_range(CSR_LAST_UNUSED, CSR_FIRST_UNUSED)),
                         CSR_DATA_W'($urandom));
            for (n = 0; n < 70; n++)
               send_reading(pick_count(), ($urandom_range(19) == 0), 1'b0, '0);
         end
      end

      // Run with a large positive error so the integral grows far enough to
      // saturate the drive; the integral gain flips sign halfway to saturate it both ways.
      wait_for_drain();
      write_reg(CSR_SETPOINT, 31'h0000_7FFF);
      write_reg(CSR_INTEGRAL_LIMIT, '1);
      write_reg(CSR_GAIN_I, 31'h0000_7FFF);
      write_reg(CSR_GAIN_P, pick_reg_word(1'b0));
      write_reg(CSR_GAIN_D, pick_reg_word(1'b0));
      for (n = 0; n < FLOOD_ITEMS; n++)
         send_reading(COUNT_W'($urandom_range(65535, 60000)), 1'b0, 1'b0, '0);
      wait_for_drain();
      write_reg(CSR_GAIN_I, 31'h0000_8000);
      for (n = 0; n < FLOOD_ITEMS; n++)
         send_reading(COUNT_W'($urandom_range(65535, 60000)), 1'b0, 1'b0, '0);

      req_if.valid <= 1'b0;
      csr_write_en <= 1'b0;
      for (drain_cycles = 0; drive_q.size() != 0 && drain_cycles < 100000; drain_cycles++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (drive_q.size() != 0) begin
         failures += drive_q.size();
         $display("%0d expected drive values never arrived", drive_q.size());
      end

      $display("Sent %0d encoder readings and checked %0d drive values over %0d register writes.",
               readings, checked, reg_writes);
      $display("Integral clamps: %0d, integral floor hits: %0d, saturated drives: %0d.",
               clamp_hits, floor_hits, drive_sat_hits);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
